@@ hdl/tlrp_pkg.sv @@
// ----------------------------------------------------------------------------
// tlrp_pkg
// Shared types and character codes for the text line radio packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlrp_pkg;

  // Line-end characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Field widths of one beat on either channel
  localparam int unsigned CH_W   = 8;
  localparam int unsigned NODE_W = 32;
  localparam int unsigned PORT_W = 8;

  typedef logic [CH_W-1:0]   byte_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [PORT_W-1:0] port_t;

endpackage

`default_nettype wire

@@ hdl/tlrp_if.sv @@
// ----------------------------------------------------------------------------
// tlrp_in_if / tlrp_out_if
// Valid/ready channels for incoming characters and outgoing packet bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlrp_in_if;
  import tlrp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t ch;
  node_t peer_node;
  port_t peer_port;
  logic  end_of_message;

  modport source (output valid, ch, peer_node, peer_port, end_of_message, input ready);
  modport sink   (input valid, ch, peer_node, peer_port, end_of_message, output ready);
endinterface

interface tlrp_out_if;
  import tlrp_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  node_t dest_node;
  port_t dest_port;
  logic  packet_last;

  modport source (output valid, out_byte, dest_node, dest_port, packet_last, input ready);
  modport sink   (input valid, out_byte, dest_node, dest_port, packet_last, output ready);
endinterface

`default_nettype wire

@@ hdl/text_line_radio_packetizer_top.sv @@
// ----------------------------------------------------------------------------
// text_line_radio_packetizer_top
// Packs text characters into radio payloads of up to PAYLOAD_BYTES bytes, one byte per beat.
// ----------------------------------------------------------------------------
// A character that sends nothing is taken while the block stays ready for
// the next one. A packet goes out of a payload RAM with one write and one
// registered read port at one byte per cycle while the output takes each
// beat, after a read setup state (ST_EM_RD), and input is held off while it
// streams; when CR LF is appended, the LF is first written in its own state
// (ST_LF). A destination change with pending bytes first sends those bytes
// to the old peer, then handles the character in ST_APPLY, which may start
// a packet of its own. Output back-pressure stalls the packet stream; a
// finished byte may sit in the output register while the next character is
// taken. The payload RAM is not cleared at reset and needs no clearing pass:
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_radio_packetizer_top #(
  parameter int unsigned PAYLOAD_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tlrp_in_if.sink          in_if,
  tlrp_out_if.source       out_if
);
  import tlrp_pkg::*;

  localparam int unsigned AW = $clog2(PAYLOAD_BYTES);      // RAM index / fill
  localparam int unsigned LW = $clog2(PAYLOAD_BYTES + 1);  // packet length
  localparam int unsigned CW = LW + 1;                     // room compare

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_LF,
    ST_EM_RD,
    ST_EM_WT
  } state_t;

  state_t        state_r, state_nxt;
  state_t        em_ret_r, em_ret_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  node_t         cur_node_r, cur_node_nxt;
  port_t         cur_port_r, cur_port_nxt;
  logic          disc_r, disc_nxt;

  // Character held across a flush
  byte_t         ch_r, ch_nxt;
  node_t         node_r, node_nxt;
  port_t         port_r, port_nxt;
  logic          eom_r, eom_nxt;

  // Packet emission
  logic [LW-1:0] em_len_r, em_len_nxt;
  logic [AW-1:0] em_idx_r, em_idx_nxt;
  node_t         em_node_r, em_node_nxt;
  port_t         em_port_r, em_port_nxt;

  // Output register
  logic          out_valid_r;
  byte_t         out_byte_r;
  node_t         out_node_r;
  port_t         out_port_r;
  logic          out_last_r;

  // Payload RAM
  byte_t         payload_mem [PAYLOAD_BYTES];
  byte_t         rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  byte_t         wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          in_fire;
  logic          dest_diff;
  logic          do_apply;
  logic          out_load;
  logic          em_last;
  byte_t         ap_ch;
  node_t         ap_node;
  port_t         ap_port;
  logic          ap_eom;
  logic          ap_le;
  logic          ap_room;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign dest_diff   = (in_if.peer_node != cur_node_r) || (in_if.peer_port != cur_port_r);

  // Pick the character: straight from the port, or held after a flush
  assign ap_ch   = (state_r == ST_APPLY) ? ch_r   : in_if.ch;
  assign ap_node = (state_r == ST_APPLY) ? node_r : in_if.peer_node;
  assign ap_port = (state_r == ST_APPLY) ? port_r : in_if.peer_port;
  assign ap_eom  = (state_r == ST_APPLY) ? eom_r  : in_if.end_of_message;
  assign ap_le   = (ap_ch == CH_CR) || (ap_ch == CH_LF);
  assign ap_room = (CW'(fill_r) + CW'(3)) < CW'(PAYLOAD_BYTES);

  assign out_load = (state_r == ST_EM_WT) && (!out_valid_r || out_if.ready);
  assign em_last  = ((LW'(em_idx_r) + LW'(1)) == em_len_r);

  // Sequencer: drop, flush, store, append line end, stream packet
  always_comb begin
    state_nxt    = state_r;
    em_ret_nxt   = em_ret_r;
    fill_nxt     = fill_r;
    cur_node_nxt = cur_node_r;
    cur_port_nxt = cur_port_r;
    disc_nxt     = disc_r;
    ch_nxt       = ch_r;
    node_nxt     = node_r;
    port_nxt     = port_r;
    eom_nxt      = eom_r;
    em_len_nxt   = em_len_r;
    em_idx_nxt   = em_idx_r;
    em_node_nxt  = em_node_r;
    em_port_nxt  = em_port_r;
    wr_en        = 1'b0;
    wr_addr      = fill_r;
    wr_data      = ap_ch;
    rd_en        = 1'b0;
    rd_addr      = em_idx_r;
    do_apply     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (disc_r) begin
            // Drop the rest of a message after its line end
            if (in_if.end_of_message) begin
              disc_nxt = 1'b0;
            end
          end else if (dest_diff && (fill_r != '0)) begin
            // Flush pending bytes to the old peer, then handle the character
            ch_nxt       = in_if.ch;
            node_nxt     = in_if.peer_node;
            port_nxt     = in_if.peer_port;
            eom_nxt      = in_if.end_of_message;
            em_len_nxt   = LW'(fill_r);
            em_node_nxt  = cur_node_r;
            em_port_nxt  = cur_port_r;
            em_idx_nxt   = '0;
            em_ret_nxt   = ST_APPLY;
            state_nxt    = ST_EM_RD;
            cur_node_nxt = in_if.peer_node;
            cur_port_nxt = in_if.peer_port;
            fill_nxt     = '0;
          end else begin
            cur_node_nxt = in_if.peer_node;
            cur_port_nxt = in_if.peer_port;
            do_apply     = 1'b1;
          end
        end
      end
      ST_APPLY: begin
        do_apply = 1'b1;
      end
      ST_LF: begin
        // Write LF after CR, then send the line
        wr_en       = 1'b1;
        wr_addr     = fill_r + AW'(1);
        wr_data     = CH_LF;
        em_len_nxt  = LW'(fill_r) + LW'(2);
        em_node_nxt = cur_node_r;
        em_port_nxt = cur_port_r;
        em_idx_nxt  = '0;
        em_ret_nxt  = ST_IDLE;
        state_nxt   = ST_EM_RD;
        fill_nxt    = '0;
      end
      ST_EM_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_EM_WT;
      end
      ST_EM_WT: begin
        // Advance one byte each time the output register takes one
        if (out_load) begin
          if (em_last) begin
            state_nxt = em_ret_r;
          end else begin
            em_idx_nxt = em_idx_r + AW'(1);
            rd_en      = 1'b1;
            rd_addr    = em_idx_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Handle one character against the current buffer
    if (do_apply) begin
      state_nxt = ST_IDLE;
      if (!ap_le) begin
        wr_en   = 1'b1;
        wr_addr = fill_r;
        wr_data = ap_ch;
        if (fill_r == AW'(PAYLOAD_BYTES - 1)) begin
          em_len_nxt  = LW'(PAYLOAD_BYTES);
          em_node_nxt = ap_node;
          em_port_nxt = ap_port;
          em_idx_nxt  = '0;
          em_ret_nxt  = ST_IDLE;
          state_nxt   = ST_EM_RD;
          fill_nxt    = '0;
        end else begin
          fill_nxt = fill_r + AW'(1);
        end
      end else begin
        disc_nxt = !ap_eom;
        if (ap_room) begin
          wr_en     = 1'b1;
          wr_addr   = fill_r;
          wr_data   = CH_CR;
          state_nxt = ST_LF;
        end else begin
          em_len_nxt  = LW'(fill_r);
          em_node_nxt = ap_node;
          em_port_nxt = ap_port;
          em_idx_nxt  = '0;
          em_ret_nxt  = ST_IDLE;
          state_nxt   = ST_EM_RD;
          fill_nxt    = '0;
        end
      end
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      em_ret_r    <= ST_IDLE;
      fill_r      <= '0;
      cur_node_r  <= '0;
      cur_port_r  <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      em_ret_r   <= em_ret_nxt;
      fill_r     <= fill_nxt;
      cur_node_r <= cur_node_nxt;
      cur_port_r <= cur_port_nxt;
      disc_r     <= disc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    node_r    <= node_nxt;
    port_r    <= port_nxt;
    eom_r     <= eom_nxt;
    em_len_r  <= em_len_nxt;
    em_idx_r  <= em_idx_nxt;
    em_node_r <= em_node_nxt;
    em_port_r <= em_port_nxt;
    if (out_load) begin
      out_byte_r <= rd_data_r;
      out_node_r <= em_node_r;
      out_port_r <= em_port_r;
      out_last_r <= em_last;
    end
  end

  // Payload RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      payload_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= payload_mem[rd_addr];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.dest_node   = out_node_r;
  assign out_if.dest_port   = out_port_r;
  assign out_if.packet_last = out_last_r;

  // A beat appears only from the packet streaming state
  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_EM_WT))
    else $error("output beat loaded outside packet streaming");

  // After a flush the buffer starts empty
  a_apply_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY) |-> (fill_r == '0))
    else $error("character handled after flush with pending bytes");

  // CR LF is appended only where both bytes and the slack fit
  a_lf_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LF) |-> ((CW'(fill_r) + CW'(3)) < CW'(PAYLOAD_BYTES)))
    else $error("line end appended without room");

  // No empty packet is ever started
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_RD) |-> (em_len_r != '0))
    else $error("empty packet started");

  // Input is held off while a packet streams
  a_no_accept_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EM_RD) || (state_r == ST_EM_WT)) |-> !in_if.ready)
    else $error("input taken during packet streaming");

endmodule

`default_nettype wire

@@ verif/text_line_radio_packetizer_top_test.sv @@
// ----------------------------------------------------------------------------
// text_line_radio_packetizer_top_test
// Self-checking bench for the text line radio packetizer. Character beats go
// in from a queue. Each accepted character updates a local copy of the
// payload buffer, fill count, peer and discard flag, and that copy predicts
// the packet bytes. A monitor compares every output beat with the oldest
// predicted byte. Both sides idle at random, and the receiver holds off once
// for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module text_line_radio_packetizer_top_test;
  import tlrp_pkg::*;

  localparam int unsigned PAYLOAD_BYTES   = 32;
  localparam int unsigned DRAIN_CYCLES    = 2 * PAYLOAD_BYTES + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned RANDOM_CHARS    = 160;

  typedef struct {
    byte_t ch;
    node_t node;
    port_t port;
    logic  eom;
  } char_beat_t;

  typedef struct {
    byte_t data;
    node_t node;
    port_t port;
    logic  last;
  } packet_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tlrp_in_if  in_if ();
  tlrp_out_if out_if ();

  text_line_radio_packetizer_top #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always #5 clk = ~clk;

  // Packetizer state as seen by the bench
  byte_t       payload_copy [PAYLOAD_BYTES];
  int unsigned fill_level;
  node_t       peer_node_now;
  port_t       peer_port_now;
  bit          dropping_rest;

  char_beat_t   pending_chars [$];
  packet_byte_t expected_bytes [$];

  int unsigned errors      = 0;
  int unsigned chars_taken = 0;
  int unsigned in_gap      = 0;
  int unsigned out_stall   = 0;
  bit          hold_long   = 1'b0;

  node_t peer_nodes [4];
  port_t peer_ports [4];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: MISMATCH %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // Every third stretch of 40 characters runs with no idling on either side
  function automatic int unsigned pick_idle();
    int unsigned r;
    if ((chars_taken / 40) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_packet(int unsigned len, node_t node, port_t port);
    packet_byte_t b;
    for (int unsigned i = 0; i < len && i < PAYLOAD_BYTES; i++) begin
      b.data = payload_copy[i];
      b.node = node;
      b.port = port;
      b.last = (i + 1 == len);
      expected_bytes.push_back(b);
    end
  endfunction

  // Advance the packetizer state by one accepted character
  function automatic void pack_char(char_beat_t c);
    if (dropping_rest) begin
      if (c.eom) dropping_rest = 1'b0;
      return;
    end
    if (c.node != peer_node_now || c.port != peer_port_now) begin
      if (fill_level > 0) queue_packet(fill_level, peer_node_now, peer_port_now);
      fill_level    = 0;
      peer_node_now = c.node;
      peer_port_now = c.port;
    end
    if (c.ch != CH_CR && c.ch != CH_LF) begin
      payload_copy[fill_level] = c.ch;
      fill_level++;
      if (fill_level >= PAYLOAD_BYTES) begin
        queue_packet(PAYLOAD_BYTES, c.node, c.port);
        fill_level = 0;
      end
      return;
    end
    // Line end: append CR LF only when it fits
    if (fill_level + 3 < PAYLOAD_BYTES) begin
      payload_copy[fill_level]     = CH_CR;
      payload_copy[fill_level + 1] = CH_LF;
      fill_level += 2;
    end
    queue_packet(fill_level, c.node, c.port);
    fill_level    = 0;
    dropping_rest = !c.eom;
  endfunction

  task automatic add_char(byte_t ch, node_t node, port_t port, logic eom);
    char_beat_t c;
    c.ch   = ch;
    c.node = node;
    c.port = port;
    c.eom  = eom;
    pending_chars.push_back(c);
  endtask

  task automatic add_text(string s, node_t node, port_t port, logic eom_last);
    for (int i = 0; i < s.len(); i++)
      add_char(s[i], node, port, eom_last && (i == s.len() - 1));
  endtask

  // Body character: any nonzero byte but a line end
  function automatic byte_t text_char();
    byte_t ch;
    ch = byte_t'($urandom_range(1, 255));
    if (ch == CH_CR || ch == CH_LF) ch = ch ^ 8'h40;
    return ch;
  endfunction

  function automatic byte_t line_end();
    return $urandom_range(0, 1) ? CH_CR : CH_LF;
  endfunction

  // Input driver: hold a beat until taken, then idle or offer the next one
  always @(posedge clk) begin : drive_chars
    char_beat_t c;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        c.ch   = in_if.ch;
        c.node = in_if.peer_node;
        c.port = in_if.peer_port;
        c.eom  = in_if.end_of_message;
        pack_char(c);
        chars_taken++;
        in_gap = pick_idle();
      end
      if (!(in_if.valid && !in_if.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          c = pending_chars.pop_front();
          in_if.ch             <= c.ch;
          in_if.peer_node      <= c.node;
          in_if.peer_port      <= c.port;
          in_if.end_of_message <= c.eom;
          in_if.valid          <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each packet beat, then pick the next ready
  always @(posedge clk) begin : watch_bytes
    packet_byte_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("packet byte with none pending", 32'(out_if.out_byte), 32'd0);
        end else begin
          e = expected_bytes.pop_front();
          if (out_if.out_byte !== e.data)
            report_mismatch("out_byte", 32'(out_if.out_byte), 32'(e.data));
          if (out_if.dest_node !== e.node)
            report_mismatch("dest_node", out_if.dest_node, e.node);
          if (out_if.dest_port !== e.port)
            report_mismatch("dest_port", 32'(out_if.dest_port), 32'(e.port));
          if (out_if.packet_last !== e.last)
            report_mismatch("packet_last", 32'(out_if.packet_last), 32'(e.last));
        end
      end
      if (hold_long) begin
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = pick_idle();
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering characters
  initial begin : hold_off
    wait (chars_taken >= 60);
    @(posedge clk);
    hold_long <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_long <= 1'b0;
  end

  initial begin : run_limit
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned made;
    int unsigned kind;
    int unsigned len;
    int unsigned idx;
    node_t       node;
    port_t       port;
    node_t       node2;
    port_t       port2;

    in_if.valid          = 1'b0;
    in_if.ch             = '0;
    in_if.peer_node      = '0;
    in_if.peer_port      = '0;
    in_if.end_of_message = 1'b0;
    out_if.ready         = 1'b0;

    fill_level    = 0;
    peer_node_now = '0;
    peer_port_now = '0;
    dropping_rest = 1'b0;

    // Directed: extremes of the character, zero character, peer at reset
    add_char(8'h01, 32'h0, 8'h00, 1'b0);
    add_char(8'hFF, 32'h0, 8'h00, 1'b0);
    add_char(8'h00, 32'h0, 8'h00, 1'b0);
    add_char(CH_LF, 32'h0, 8'h00, 1'b1);
    // Line end on an empty buffer, new peer at the top of both ranges
    add_char(CH_CR, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Line end inside a message: drop the rest up to its end
    add_text("ab", 32'hFFFF_FFFF, 8'hFF, 1'b0);
    add_char(CH_LF, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    add_text("xyz", 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Message with no line end stays pending for the next one
    add_text("pq", 32'hFFFF_FFFF, 8'hFF, 1'b1);
    add_char("r", 32'hFFFF_FFFF, 8'hFF, 1'b0);
    add_char(CH_CR, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    // Peer change mid message flushes to the old peer
    add_text("mn", 32'hFFFF_FFFF, 8'hFF, 1'b0);
    add_char("o", 32'h1234_5678, 8'h5A, 1'b0);
    add_char(CH_LF, 32'h1234_5678, 8'h5A, 1'b1);
    // Dropped characters skip the peer check
    add_char(CH_LF, 32'h1, 8'h01, 1'b0);
    add_char("j", 32'h2, 8'h02, 1'b1);
    add_char("k", 32'h1, 8'h01, 1'b1);

    peer_nodes[0] = 32'h0;
    peer_ports[0] = 8'h00;
    peer_nodes[1] = 32'hFFFF_FFFF;
    peer_ports[1] = 8'hFF;
    peer_nodes[2] = 32'h1234_5678;
    peer_ports[2] = 8'h5A;
    peer_nodes[3] = $urandom;
    peer_ports[3] = port_t'($urandom);

    // Random messages, mostly well formed, some broken
    made = 0;
    while (made < RANDOM_CHARS) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80) begin
        idx  = $urandom_range(0, 3);
        node = peer_nodes[idx];
        port = peer_ports[idx];
      end else begin
        node = $urandom;
        port = port_t'($urandom);
      end
      idx   = $urandom_range(0, 3);
      node2 = peer_nodes[idx];
      port2 = peer_ports[idx];
      len   = ($urandom_range(0, 99) < 75) ? $urandom_range(0, 10) : $urandom_range(26, 40);

      if (kind < 55) begin
        // Plain line
        for (int unsigned i = 0; i < len; i++) add_char(text_char(), node, port, 1'b0);
        add_char(line_end(), node, port, 1'b1);
        made += len + 1;
      end else if (kind < 70) begin
        // Line end before the message ends, then characters that get dropped
        for (int unsigned i = 0; i < len; i++) add_char(text_char(), node, port, 1'b0);
        add_char(line_end(), node, port, 1'b0);
        idx = $urandom_range(1, 4);
        for (int unsigned i = 0; i < idx; i++) begin
          if ($urandom_range(0, 3) == 0)
            add_char(line_end(), $urandom, port_t'($urandom), i + 1 == idx);
          else
            add_char(text_char(), $urandom, port_t'($urandom), i + 1 == idx);
        end
        made += len + 1;
      end else if (kind < 85) begin
        // Message with no line end
        if (len == 0) len = 1;
        for (int unsigned i = 0; i < len; i++)
          add_char(text_char(), node, port, i + 1 == len);
        made += len;
      end else if (kind < 93) begin
        // Peer changes partway through the message
        for (int unsigned i = 0; i < len / 2; i++) add_char(text_char(), node, port, 1'b0);
        for (int unsigned i = len / 2; i < len; i++)
          add_char(text_char(), node2, port2, 1'b0);
        add_char(line_end(), node2, port2, 1'b1);
        made += len + 1;
      end else begin
        // Nearly full buffer flushed by a line end to another peer
        for (int unsigned i = 0; i < PAYLOAD_BYTES - 1; i++)
          add_char(text_char(), node, port, 1'b0);
        if (node2 == node && port2 == port) port2 = port ^ 8'h01;
        add_char(line_end(), node2, port2, 1'b1);
        made += PAYLOAD_BYTES;
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every character to go in and every packet byte to come out
    while (pending_chars.size() > 0 || in_if.valid || expected_bytes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
